FILE: rtl/pclc_pkg.sv
// Package: constants, status codes and record type for the packet checker.
`timescale 1ns / 1ps
package pclc_pkg;

  localparam int PACKET_BYTES   = 138;
  localparam int ID_POSITION    = 9;
  localparam int CHECK_POSITION = 8;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 32;

  localparam logic [BYTE_W-1:0] POS_MAX   = {BYTE_W{1'b1}};
  localparam logic [BYTE_W-1:0] LAST_POS  = BYTE_W'(PACKET_BYTES - 1);
  localparam logic [BYTE_W-1:0] ID_POS    = BYTE_W'(ID_POSITION);
  localparam logic [BYTE_W-1:0] CHECK_POS = BYTE_W'(CHECK_POSITION);

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_LEN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SUM = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              len_ok;
    logic              sum_ok;
    logic [BYTE_W-1:0] id;
  } pkt_rec_t;

endpackage

FILE: rtl/pclc_if.sv
// Interfaces: byte input channel and per-packet result channel.
`timescale 1ns / 1ps
interface pclc_in_if;
  logic                      valid;
  logic                      ready;
  logic [pclc_pkg::BYTE_W-1:0] data_byte;
  logic                      last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface pclc_out_if;
  logic                         valid;
  logic                         ready;
  logic [pclc_pkg::STATUS_W-1:0] status;
  logic [pclc_pkg::BYTE_W-1:0]   sequence_id;
  logic                         first_packet;
  logic                         gap_seen;
  logic [pclc_pkg::BYTE_W-1:0]   packets_missed;
  logic [pclc_pkg::COUNT_W-1:0]  lost_total;
  logic [pclc_pkg::COUNT_W-1:0]  received_total;

  modport source(output valid, status, sequence_id, first_packet, gap_seen,
                 packets_missed, lost_total, received_total, input ready);
  modport sink(input valid, status, sequence_id, first_packet, gap_seen,
               packets_missed, lost_total, received_total, output ready);
endinterface

FILE: rtl/pclc_front.sv
// Front end: takes bytes, tracks position, checksum, id; emits one record per packet.
`timescale 1ns / 1ps
module pclc_front (
  input  logic               clk,
  input  logic               rst,
  pclc_in_if.sink            pkt,
  output logic               rec_valid,
  input  logic               rec_ready,
  output pclc_pkg::pkt_rec_t rec
);
  import pclc_pkg::*;

  logic [BYTE_W-1:0] pos;
  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] check;
  logic [BYTE_W-1:0] id;
  logic [BYTE_W-1:0] sum_next;
  logic [BYTE_W-1:0] check_next;
  logic [BYTE_W-1:0] id_next;
  logic              xfer;

  assign pkt.ready = rec_ready;
  assign xfer      = pkt.valid && pkt.ready;

  always_comb begin
    check_next = (pos == CHECK_POS) ? pkt.data_byte : check;
    id_next    = (pos == ID_POS) ? pkt.data_byte : id;
    sum_next   = (pos >= ID_POS) ? (sum ^ pkt.data_byte) : sum;
  end

  assign rec_valid  = xfer && pkt.last_byte;
  assign rec.len_ok = (pos == LAST_POS);
  assign rec.sum_ok = (sum_next == check_next);
  assign rec.id     = id_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      sum   <= '0;
      check <= '0;
      id    <= '0;
    end else if (xfer) begin
      if (pkt.last_byte) begin
        pos   <= '0;
        sum   <= '0;
        check <= '0;
        id    <= '0;
      end else begin
        pos   <= (pos == POS_MAX) ? pos : pos + 1'b1;
        sum   <= sum_next;
        check <= check_next;
        id    <= id_next;
      end
    end
  end

  a_pos_clear: assert property (@(posedge clk) disable iff (rst)
    xfer && pkt.last_byte |=> pos == '0 && sum == '0)
    else $error("packet state not cleared after last byte");

endmodule

FILE: rtl/pclc_fifo.sv
// Short record queue between front and back ends.
`timescale 1ns / 1ps
module pclc_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  pclc_pkg::pkt_rec_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output pclc_pkg::pkt_rec_t pop_data
);
  import pclc_pkg::*;

  pkt_rec_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: rtl/pclc_back.sv
// Back end: sequence gap and totals per packet record, registered result.
`timescale 1ns / 1ps
module pclc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  output logic               rec_ready,
  input  pclc_pkg::pkt_rec_t rec,
  pclc_out_if.source         res
);
  import pclc_pkg::*;

  logic [BYTE_W-1:0]  prev_id;
  logic               seen_first;
  logic [COUNT_W-1:0] recv;
  logic [COUNT_W-1:0] lost;
  logic [COUNT_W-1:0] recv_next;
  logic [COUNT_W-1:0] lost_next;
  logic [BYTE_W-1:0]  missed_next;
  logic               res_valid;
  logic               pop;

  assign rec_ready = !res_valid || res.ready;
  assign pop       = rec_valid && rec_ready;
  assign res.valid = res_valid;

  always_comb begin
    missed_next = '0;
    recv_next   = recv;
    lost_next   = lost;
    if (rec.len_ok) begin
      recv_next = recv + 1'b1;
      if (seen_first) begin
        missed_next = rec.id - prev_id - 1'b1;
        lost_next   = lost + COUNT_W'(missed_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      prev_id    <= '0;
      seen_first <= 1'b0;
      recv       <= '0;
      lost       <= '0;
    end else begin
      if (pop) begin
        res_valid <= 1'b1;
        recv      <= recv_next;
        lost      <= lost_next;
        if (rec.len_ok) begin
          prev_id    <= rec.id;
          seen_first <= 1'b1;
        end
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.lost_total     <= lost_next;
      res.received_total <= recv_next;
      res.packets_missed <= missed_next;
      res.gap_seen       <= (missed_next != '0);
      if (rec.len_ok) begin
        res.status       <= rec.sum_ok ? STATUS_OK : STATUS_BAD_SUM;
        res.sequence_id  <= rec.id;
        res.first_packet <= !seen_first;
      end else begin
        res.status       <= STATUS_BAD_LEN;
        res.sequence_id  <= '0;
        res.first_packet <= 1'b0;
      end
    end
  end

  a_recv_step: assert property (@(posedge clk) disable iff (rst)
    pop && rec.len_ok |=> recv == $past(recv) + 1'b1)
    else $error("received count did not step on good packet");

  a_badlen_quiet: assert property (@(posedge clk) disable iff (rst)
    pop && !rec.len_ok |=> recv == $past(recv) && lost == $past(lost))
    else $error("bad length packet changed totals");

  a_first_once: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.first_packet |-> res.packets_missed == '0 && !res.gap_seen
      && res.received_total == 32'd1 + (recv - res.received_total))
    else $error("first packet reported a gap");

endmodule

FILE: rtl/packet_check_and_loss_counter.sv
// Top level: packet length and XOR check with sequence loss counting.
`timescale 1ns / 1ps
// Takes one packet byte per cycle on pkt, with last_byte on the final byte, and
// gives one result per packet on res. A byte is accepted every cycle while the
// two-entry record queue between the byte front end and the counter back end
// has room; it fills only while res is stalled. The result of a packet is
// held first in the queue, then in the result register of the back end.
// Packets of the wrong length report status 1 and leave the totals alone;
// a checksum mismatch reports status 2 but the packet is still counted and
// its sequence gap still added.
module packet_check_and_loss_counter (
  input  logic       clk,
  input  logic       rst,
  pclc_in_if.sink    pkt,
  pclc_out_if.source res
);
  import pclc_pkg::*;

  logic     front_valid;
  logic     front_ready;
  pkt_rec_t front_rec;
  logic     back_valid;
  logic     back_ready;
  pkt_rec_t back_rec;

  pclc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt),
    .rec_valid (front_valid),
    .rec_ready (front_ready),
    .rec       (front_rec)
  );

  pclc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_rec),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_rec)
  );

  pclc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (back_valid),
    .rec_ready (back_ready),
    .rec       (back_rec),
    .res       (res)
  );

endmodule

FILE: tb/sv/testbench.sv
// Testbench: random and directed packet traffic with a per-packet result scoreboard.
`timescale 1ns / 1ps
module testbench;
  import pclc_pkg::*;

  localparam longint CYCLE_LIMIT = 1_500_000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     BYTE_BUDGET = 1200;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   sequence_id;
    logic                first_packet;
    logic                gap_seen;
    logic [BYTE_W-1:0]   packets_missed;
    logic [COUNT_W-1:0]  lost_total;
    logic [COUNT_W-1:0]  received_total;
  } pkt_result_t;

  class loss_scoreboard;
    logic [BYTE_W-1:0]  position, xor_acc, check_byte, cur_id, prev_id;
    bit                 seen_first;
    logic [COUNT_W-1:0] received, lost;
    pkt_result_t        pending[$];
    int errors, checked, n_ok, n_bad_len, n_bad_sum, n_gap;

    function new();
      position   = '0;
      xor_acc    = '0;
      check_byte = '0;
      cur_id     = '0;
      prev_id    = '0;
      seen_first = 1'b0;
      received   = '0;
      lost       = '0;
      errors     = 0;
      checked    = 0;
      n_ok       = 0;
      n_bad_len  = 0;
      n_bad_sum  = 0;
      n_gap      = 0;
    endfunction

    // one accepted byte transfer; queues the packet result on the last byte
    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      logic [BYTE_W-1:0] pos;
      logic [BYTE_W-1:0] missed;
      pkt_result_t r;
      pos = position;
      if (pos == CHECK_POS) check_byte = b;
      if (pos == ID_POS) cur_id = b;
      if (pos >= ID_POS) xor_acc = xor_acc ^ b;
      if (pos != POS_MAX) position = pos + 1'b1;
      if (!last) return;
      r = '0;
      if (pos == POS_MAX || pos != LAST_POS) begin
        r.status = STATUS_BAD_LEN;
      end else begin
        received = received + 1'b1;
        r.sequence_id = cur_id;
        if (!seen_first) begin
          seen_first = 1'b1;
          r.first_packet = 1'b1;
        end else begin
          missed = cur_id - prev_id - 1'b1;
          r.packets_missed = missed;
          r.gap_seen = (missed != '0);
          lost = lost + COUNT_W'(missed);
        end
        prev_id = cur_id;
        r.status = (xor_acc == check_byte) ? STATUS_OK : STATUS_BAD_SUM;
      end
      r.lost_total = lost;
      r.received_total = received;
      pending.push_back(r);
      position   = '0;
      xor_acc    = '0;
      check_byte = '0;
      cur_id     = '0;
    endfunction

    function int field_diff(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_result(pkt_result_t got);
      pkt_result_t want;
      if (pending.size() == 0) begin
        $error("result transfer with no packet pending (status %0d)", got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      case (want.status)
        STATUS_OK:      n_ok++;
        STATUS_BAD_LEN: n_bad_len++;
        default:        n_bad_sum++;
      endcase
      if (want.gap_seen) n_gap++;
      errors += field_diff("status", want.status, got.status);
      errors += field_diff("sequence_id", want.sequence_id, got.sequence_id);
      errors += field_diff("first_packet", want.first_packet, got.first_packet);
      errors += field_diff("gap_seen", want.gap_seen, got.gap_seen);
      errors += field_diff("packets_missed", want.packets_missed, got.packets_missed);
      errors += field_diff("lost_total", want.lost_total, got.lost_total);
      errors += field_diff("received_total", want.received_total, got.received_total);
    endfunction
  endclass

  logic clk;
  logic rst;

  pclc_in_if  bytes_in();
  pclc_out_if results();

  packet_check_and_loss_counter dut (
    .clk (clk),
    .rst (rst),
    .pkt (bytes_in),
    .res (results)
  );

  loss_scoreboard sb = new();

  bit          calm;
  int          hold_asks;
  int          holds_done;
  int          hold_left;
  int          stall_left;
  int          bytes_sent;
  longint      cycles;
  logic [7:0]  gen_id;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side: check, then decide ready for the next edge
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        sb.check_result(pkt_result_t'{results.status, results.sequence_id,
                                      results.first_packet, results.gap_seen,
                                      results.packets_missed, results.lost_total,
                                      results.received_total});
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        results.ready <= 1'b0;
      end else if (holds_done != hold_asks) begin
        holds_done <= hold_asks;
        hold_left <= HOLD_CYCLES;
        results.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        results.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                  : $urandom_range(0, 2);
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  function automatic int next_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic last);
    int g;
    bytes_in.valid     <= 1'b1;
    bytes_in.data_byte <= d;
    bytes_in.last_byte <= last;
    @(posedge clk);
    while (!bytes_in.ready) @(posedge clk);
    sb.note_byte(d, last);
    bytes_sent++;
    g = next_gap();
    if (g > 0) begin
      bytes_in.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // fill < 0 gives random content
  task automatic send_packet(input int len, input logic [7:0] id, input bit sum_ok,
                             input int fill);
    logic [7:0] pk[];
    logic [7:0] x;
    pk = new[len];
    foreach (pk[i]) pk[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    if (len > ID_POSITION) pk[ID_POSITION] = id;
    x = '0;
    for (int i = ID_POSITION; i < len; i++) x = x ^ pk[i];
    if (len > CHECK_POSITION)
      pk[CHECK_POSITION] = sum_ok ? x : x ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < len; i++) send_byte(pk[i], i == len - 1);
    if (len == PACKET_BYTES) gen_id = id;
  endtask

  // short packets while the result side holds off, so the block backs up
  task automatic send_burst();
    bit was_calm;
    was_calm = calm;
    calm = 1'b1;
    hold_asks <= hold_asks + 1;
    repeat (24) send_byte(8'($urandom), 1'b1);
    calm = was_calm;
  endtask

  initial begin
    int kind;
    int len;
    rst                = 1'b1;
    bytes_in.valid     = 1'b0;
    bytes_in.data_byte = '0;
    bytes_in.last_byte = 1'b0;
    results.ready      = 1'b0;
    calm       = 1'b1;
    hold_asks  = 0;
    holds_done = 0;
    hold_left  = 0;
    stall_left = 0;
    bytes_sent = 0;
    cycles     = 0;
    gen_id     = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_packet(1, 8'h00, 1'b1, 255);
    send_packet(10, 8'h06, 1'b1, -1);
    send_packet(PACKET_BYTES, 8'h00, 1'b1, 0);
    calm = 1'b0;
    send_packet(PACKET_BYTES, 8'h01, 1'b1, 255);
    send_packet(PACKET_BYTES, 8'hFF, 1'b1, -1);
    send_packet(PACKET_BYTES, 8'h00, 1'b0, -1);
    send_packet(256, 8'h02, 1'b1, -1);
    send_burst();

    // random
    while (bytes_sent < BYTE_BUDGET) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = PACKET_BYTES;
        send_packet(len, gen_id + 8'd1, 1'b1, -1);
      end else if (kind < 65) begin
        len = PACKET_BYTES;
        send_packet(len, 8'($urandom), 1'b1, -1);
      end else if (kind < 75) begin
        len = PACKET_BYTES;
        send_packet(len, gen_id + 8'd1, 1'b0, -1);
      end else if (kind < 85) begin
        len = $urandom_range(1, PACKET_BYTES - 1);
        send_packet(len, 8'($urandom), 1'b1, -1);
      end else if (kind < 93) begin
        len = $urandom_range(PACKET_BYTES + 1, 254);
        send_packet(len, 8'($urandom), 1'b1, -1);
      end else if (kind < 97) begin
        len = $urandom_range(255, 280);
        send_packet(len, 8'($urandom), 1'b1, -1);
      end else begin
        send_burst();
      end
    end
    bytes_in.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d byte transfers, %0d packet results checked: %0d ok, %0d bad length, %0d bad checksum",
             bytes_sent, sb.checked, sb.n_ok, sb.n_bad_len, sb.n_bad_sum);
    $display("summary: %0d packets with a sequence gap, %0d lost in total, %0d back-pressure holds",
             sb.n_gap, sb.lost, hold_asks);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
